### src/i2c_master_transfer_sequencer_unit_assert.svh
// ============================================================================
// I2C master transfer sequencer - assertion macros
// Shared concurrent-assertion forms, clocked on aclk and quiet in reset.
// ============================================================================
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_UNIT_ASSERT_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication
`define I2CMS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define I2CMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/i2cms_pkg.sv
// ============================================================================
// i2cms_pkg
// Shared types and codes of the I2C master transfer sequencer.
// ============================================================================
package i2cms_pkg;

    // Message buffer geometry
    localparam int BUF_DEPTH = 256;
    localparam int ADDR_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    // Command codes (s_tuser)
    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_START  = 2'd1,
        CMD_STATUS = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    // Bus status codes
    localparam logic [7:0] ST_START       = 8'h08;
    localparam logic [7:0] ST_RESTART     = 8'h10;
    localparam logic [7:0] ST_SLA_W_ACK   = 8'h18;
    localparam logic [7:0] ST_SLA_W_NACK  = 8'h20;
    localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
    localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
    localparam logic [7:0] ST_SLA_R_ACK   = 8'h40;
    localparam logic [7:0] ST_SLA_R_NACK  = 8'h48;
    localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
    localparam logic [7:0] ST_DATA_R_LAST = 8'h58;

    // Link state codes
    localparam logic [1:0] LINK_BUSY = 2'd0;
    localparam logic [1:0] LINK_OK   = 2'd1;
    localparam logic [1:0] LINK_FAIL = 2'd2;

    // Control word and byte selection of one step
    typedef struct packed {
        logic       ctrl_write;
        logic       stay_busy;
        logic       issue_start;
        logic       issue_stop;
        logic       send_ack;
        logic       tx_load;
        logic       tx_sel;     // tx_byte comes from buffer read
        logic       rd_sel;     // read_byte comes from buffer read
        logic [1:0] link_state;
    } step_t;

    // Buffer access request
    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } mem_req_t;

endpackage

### src/i2cms_seq.sv
// ============================================================================
// i2cms_seq
// Transfer control state and per-word step decision, plus buffer request.
// ============================================================================
module i2cms_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  i2cms_pkg::cmd_t      cmd,
    input  logic [7:0]           index,
    input  logic [7:0]           data_byte,
    input  logic [7:0]           msg_length,
    input  logic [7:0]           status_code,
    output i2cms_pkg::step_t     step,
    output i2cms_pkg::mem_req_t  mem_req
);

    logic [7:0] ptr_reg, ptr_next;
    logic [7:0] len_reg, len_next;
    logic       busy_reg, busy_next;
    logic       ok_reg, ok_next;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg  <= '0;
            len_reg  <= '0;
            busy_reg <= 1'b0;
            ok_reg   <= 1'b1;
        end else if (accept) begin
            ptr_reg  <= ptr_next;
            len_reg  <= len_next;
            busy_reg <= busy_next;
            ok_reg   <= ok_next;
        end
    end

    // Step decision
    always_comb begin
        logic [7:0] ptr_eff;
        logic [7:0] ptr_inc;
        logic       idx_ok;
        logic       ptr_ok;
        logic       eff_ok;
        idx_ok  = ({1'b0, index} < 9'(i2cms_pkg::BUF_DEPTH));
        ptr_ok  = ({1'b0, ptr_reg} < 9'(i2cms_pkg::BUF_DEPTH));
        ptr_inc = ptr_reg + 8'd1;
        ptr_eff = ((status_code == i2cms_pkg::ST_START) ||
                   (status_code == i2cms_pkg::ST_RESTART)) ? 8'd0 : ptr_reg;
        eff_ok  = ({1'b0, ptr_eff} < 9'(i2cms_pkg::BUF_DEPTH));

        ptr_next  = ptr_reg;
        len_next  = len_reg;
        busy_next = busy_reg;
        ok_next   = ok_reg;
        step      = '0;
        mem_req   = '0;

        case (cmd)
            i2cms_pkg::CMD_WRITE: begin
                mem_req.en    = accept && idx_ok;
                mem_req.we    = 1'b1;
                mem_req.addr  = index[i2cms_pkg::ADDR_W-1:0];
                mem_req.wdata = data_byte;
            end
            i2cms_pkg::CMD_READ: begin
                mem_req.en   = accept && idx_ok;
                mem_req.addr = index[i2cms_pkg::ADDR_W-1:0];
                step.rd_sel  = idx_ok;
            end
            i2cms_pkg::CMD_START: begin
                if (!busy_reg) begin
                    len_next         = msg_length;
                    ok_next          = 1'b0;
                    busy_next        = 1'b1;
                    step.ctrl_write  = 1'b1;
                    step.stay_busy   = 1'b1;
                    step.issue_start = 1'b1;
                end
            end
            default: begin
                if (busy_reg) begin
                    step.ctrl_write = 1'b1;
                    case (status_code)
                        i2cms_pkg::ST_START, i2cms_pkg::ST_RESTART,
                        i2cms_pkg::ST_SLA_W_ACK, i2cms_pkg::ST_DATA_W_ACK: begin
                            if (ptr_eff < len_reg) begin
                                step.stay_busy = 1'b1;
                                step.tx_load   = 1'b1;
                                step.tx_sel    = eff_ok;
                                mem_req.en     = accept && eff_ok;
                                mem_req.addr   = ptr_eff[i2cms_pkg::ADDR_W-1:0];
                                ptr_next       = ptr_eff + 8'd1;
                            end else begin
                                ptr_next        = ptr_eff;
                                ok_next         = 1'b1;
                                busy_next       = 1'b0;
                                step.issue_stop = 1'b1;
                            end
                        end
                        i2cms_pkg::ST_SLA_W_NACK, i2cms_pkg::ST_DATA_W_NACK: begin
                            step.stay_busy   = 1'b1;
                            step.issue_start = 1'b1;
                            step.send_ack    = 1'b1;
                        end
                        i2cms_pkg::ST_DATA_R_ACK: begin
                            mem_req.en     = accept && ptr_ok;
                            mem_req.we     = 1'b1;
                            mem_req.addr   = ptr_reg[i2cms_pkg::ADDR_W-1:0];
                            mem_req.wdata  = data_byte;
                            ptr_next       = ptr_inc;
                            step.stay_busy = 1'b1;
                            step.send_ack  = (({1'b0, ptr_inc} + 9'd1) < {1'b0, len_reg});
                        end
                        i2cms_pkg::ST_SLA_R_ACK: begin
                            step.stay_busy = 1'b1;
                            step.send_ack  = (({1'b0, ptr_reg} + 9'd1) < {1'b0, len_reg});
                        end
                        i2cms_pkg::ST_DATA_R_LAST: begin
                            mem_req.en      = accept && ptr_ok;
                            mem_req.we      = 1'b1;
                            mem_req.addr    = ptr_reg[i2cms_pkg::ADDR_W-1:0];
                            mem_req.wdata   = data_byte;
                            ok_next         = 1'b1;
                            busy_next       = 1'b0;
                            step.issue_stop = 1'b1;
                            step.send_ack   = 1'b1;
                        end
                        default: begin
                            // read address NACK, lost arbitration, unknown code
                            step.stay_busy  = 1'b1;
                            step.issue_stop = 1'b1;
                            step.send_ack   = 1'b1;
                        end
                    endcase
                end
            end
        endcase

        step.link_state = busy_next ? i2cms_pkg::LINK_BUSY :
                          (ok_next ? i2cms_pkg::LINK_OK : i2cms_pkg::LINK_FAIL);
    end

endmodule

### src/i2c_master_transfer_sequencer_unit.sv
// ============================================================================
// i2c_master_transfer_sequencer_unit
// Interrupt-style I2C master transfer sequencer with a 256 x 8 message buffer.
// ============================================================================
// One word is taken per clock unless m_tready stalls the output stage, and
// each gives exactly one result word. The rate is set by the single-port
// message buffer: every word makes at most one buffer access (a write, or a
// read whose data is registered), so consecutive words never compete for the
// port. Pointer, length and flags sit in flip-flops and are updated at accept.
// The buffer has no reset and no clearing pass; an entry must be written
// before it is read or transmitted.
`include "i2c_master_transfer_sequencer_unit_assert.svh"

module i2c_master_transfer_sequencer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // index, data_byte, msg_length, status_code
    input  logic [1:0]  s_tuser,   // cmd
    // Result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // ctrl_write, stay_busy, issue_start, issue_stop,
                                   // send_ack, tx_load, tx_byte[7:0],
                                   // link_state[1:0], read_byte[7:0]
);

    logic                accept;
    logic                s1_advance;
    i2cms_pkg::step_t    step;
    i2cms_pkg::mem_req_t mem_req;

    logic                s1_valid_reg, s1_valid_next;
    i2cms_pkg::step_t    s1_step_reg;
    logic                s2_valid_reg, s2_valid_next;
    logic [23:0]         s2_data_reg;
    logic [23:0]         s2_data_next;

    logic [7:0]          buf_mem [i2cms_pkg::BUF_DEPTH];
    logic [7:0]          buf_q_reg;

    // Handshake chain
    assign s1_advance = s1_valid_reg && (!s2_valid_reg || m_tready);
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign accept     = s_tvalid && s_tready;

    // Step decision and control state
    i2cms_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .cmd         (i2cms_pkg::cmd_t'(s_tuser)),
        .index       (s_tdata[7:0]),
        .data_byte   (s_tdata[15:8]),
        .msg_length  (s_tdata[23:16]),
        .status_code (s_tdata[31:24]),
        .step        (step),
        .mem_req     (mem_req)
    );

    // Message buffer, one port, registered read
    always_ff @(posedge aclk) begin
        if (mem_req.en) begin
            if (mem_req.we) begin
                buf_mem[mem_req.addr] <= mem_req.wdata;
            end else begin
                buf_q_reg <= buf_mem[mem_req.addr];
            end
        end
    end

    // Stage valid flags
    always_comb begin
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        if (s1_advance) begin
            s2_valid_next = 1'b1;
        end else if (m_tready) begin
            s2_valid_next = 1'b0;
        end
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end
    end

    // Result word assembly from the step and buffer data
    always_comb begin
        s2_data_next = {
            (s1_step_reg.rd_sel ? buf_q_reg : 8'd0),
            s1_step_reg.link_state,
            (s1_step_reg.tx_sel ? buf_q_reg : 8'd0),
            s1_step_reg.tx_load,
            s1_step_reg.send_ack,
            s1_step_reg.issue_stop,
            s1_step_reg.issue_start,
            s1_step_reg.stay_busy,
            s1_step_reg.ctrl_write
        };
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Payload stages
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_step_reg <= step;
        end
        if (s1_advance) begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign m_tvalid = s2_valid_reg;
    assign m_tdata  = s2_data_reg;

    // Checks
    `I2CMS_ASSERT_NOW(a_buf_only_on_accept, mem_req.en, accept,
        "buffer accessed without an accepted word")
    `I2CMS_ASSERT_NOW(a_full_stall_blocks, s1_valid_reg && s2_valid_reg && !m_tready,
        !s_tready, "input ready while both stages are held")
    `I2CMS_ASSERT_NOW(a_quiet_without_ctrl, m_tvalid && !m_tdata[0], m_tdata[13:1] == 13'd0,
        "control fields set without a control word")
    `I2CMS_ASSERT_NEXT(a_accept_fills_s1, accept, s1_valid_reg,
        "accepted word lost before the output stage")

endmodule
